>>> rtl/gcbc_pkg.sv
package gcbc_pkg;

	// Fixed field widths
	localparam int PIXEL_W       = 8;
	localparam int COORD_W       = 12;
	localparam int BEAR_LEFT_W   = 8;
	localparam int BEAR_TOP_W    = 9;
	localparam int GLYPH_W_W     = 8;
	localparam int SEG_W         = 4;
	localparam int WRITE_ADDR_W  = 24;
	localparam int WRITE_VALUE_W = 32;

	// Configuration register widths
	localparam int CELL_WIDTH_W   = 7;
	localparam int CELL_HEIGHT_W  = 8;
	localparam int BASELINE_W     = 7;
	localparam int ATLAS_WIDTH_W  = 13;

	// APB port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Register indexes (word address paddr[3:2])
	localparam logic [1:0] REG_CELL_WIDTH  = 2'd0;
	localparam logic [1:0] REG_CELL_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BASELINE    = 2'd2;
	localparam logic [1:0] REG_ATLAS_WIDTH = 2'd3;

	// Reset values
	localparam logic [CELL_WIDTH_W-1:0]  CELL_WIDTH_RST  = 7'd8;
	localparam logic [CELL_HEIGHT_W-1:0] CELL_HEIGHT_RST = 8'd16;
	localparam logic [BASELINE_W-1:0]    BASELINE_RST    = 7'd12;
	localparam logic [ATLAS_WIDTH_W-1:0] ATLAS_WIDTH_RST = 13'd1024;

	// Parameter defaults
	localparam int ADDR_BITS_DEF     = 24;
	localparam int MAX_GLYPH_DIM_DEF = 256;

endpackage

>>> rtl/glyph_cell_blit_clip_core.sv
// Glyph cell blit with clipping.
// Input channel: one grayscale glyph byte per item (in_valid / in_stall), in raster
// order with no row padding, plus the cell origin, bearings, glyph width and slice
// index. glyph_last on the final byte returns the column and row counters to zero.
// Output channel: one atlas write per visible pixel (out_valid / out_stall):
// write_addr = x + y * atlas_width, write_value = the byte repeated four times.
// Bytes outside the slice or clipped by the cell produce no item.
// The input register loads at the accept edge, then the coordinate and clip stage
// and the address multiply and result register follow it in that order.
// Throughput: one item per cycle while out_stall is low; each stage advances while the
// stage after it is empty or moving, so a stalled result holds while earlier stages keep filling.
// in_stall rises only when all three stages are occupied and out_stall is high.
// Reset clears all stage valids and the counters, and loads the register defaults:
// cell_width 8, cell_height 16, baseline_row 12, atlas_width 1024.
// Registers sit on an APB port at byte addresses 0x0, 0x4, 0x8, 0xC; write them
// only while no item is in flight.
module glyph_cell_blit_clip_core #(
	parameter int ADDR_BITS     = gcbc_pkg::ADDR_BITS_DEF,
	parameter int MAX_GLYPH_DIM = gcbc_pkg::MAX_GLYPH_DIM_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [gcbc_pkg::PIXEL_W-1:0]          pixel,
	input  logic [gcbc_pkg::COORD_W-1:0]          cell_x,
	input  logic [gcbc_pkg::COORD_W-1:0]          cell_y,
	input  logic signed [gcbc_pkg::BEAR_LEFT_W-1:0] bearing_left,
	input  logic signed [gcbc_pkg::BEAR_TOP_W-1:0]  bearing_top,
	input  logic [gcbc_pkg::GLYPH_W_W-1:0]        glyph_width,
	input  logic [gcbc_pkg::SEG_W-1:0]            slice_index,
	input  logic                                  glyph_last,

	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [gcbc_pkg::WRITE_ADDR_W-1:0]     write_addr,
	output logic [gcbc_pkg::WRITE_VALUE_W-1:0]    write_value,

	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [gcbc_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [gcbc_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [gcbc_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                  pready
);

	localparam int CNT_W  = $clog2(MAX_GLYPH_DIM);
	localparam int OFS_W  = gcbc_pkg::SEG_W + gcbc_pkg::CELL_WIDTH_W;
	localparam int CMP_W  = (CNT_W > OFS_W) ? CNT_W : OFS_W;
	localparam int DY_W   = ((CNT_W > gcbc_pkg::BEAR_TOP_W) ? CNT_W : gcbc_pkg::BEAR_TOP_W) + 3;
	localparam int DX_W   = gcbc_pkg::GLYPH_W_W + 2;
	localparam int TXY_W  = gcbc_pkg::COORD_W + 1;
	localparam int PROD_W = TXY_W + gcbc_pkg::ATLAS_WIDTH_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam logic [gcbc_pkg::WRITE_ADDR_W-1:0] ADDR_MASK =
		(ADDR_BITS >= gcbc_pkg::WRITE_ADDR_W) ? '1 :
		((gcbc_pkg::WRITE_ADDR_W'(1) << ADDR_BITS) - gcbc_pkg::WRITE_ADDR_W'(1));
	localparam logic [CNT_W:0] CNT_WRAP = (CNT_W+1)'(MAX_GLYPH_DIM);

	// Configuration registers
	logic [gcbc_pkg::CELL_WIDTH_W-1:0]  cell_width_q;
	logic [gcbc_pkg::CELL_HEIGHT_W-1:0] cell_height_q;
	logic [gcbc_pkg::BASELINE_W-1:0]    baseline_q;
	logic [gcbc_pkg::ATLAS_WIDTH_W-1:0] atlas_width_q;
	logic                               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q  <= gcbc_pkg::CELL_WIDTH_RST;
			cell_height_q <= gcbc_pkg::CELL_HEIGHT_RST;
			baseline_q    <= gcbc_pkg::BASELINE_RST;
			atlas_width_q <= gcbc_pkg::ATLAS_WIDTH_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				gcbc_pkg::REG_CELL_WIDTH:  cell_width_q  <= pwdata[gcbc_pkg::CELL_WIDTH_W-1:0];
				gcbc_pkg::REG_CELL_HEIGHT: cell_height_q <= pwdata[gcbc_pkg::CELL_HEIGHT_W-1:0];
				gcbc_pkg::REG_BASELINE:    baseline_q    <= pwdata[gcbc_pkg::BASELINE_W-1:0];
				gcbc_pkg::REG_ATLAS_WIDTH: atlas_width_q <= pwdata[gcbc_pkg::ATLAS_WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			gcbc_pkg::REG_CELL_WIDTH:  prdata = gcbc_pkg::APB_DATA_W'(cell_width_q);
			gcbc_pkg::REG_CELL_HEIGHT: prdata = gcbc_pkg::APB_DATA_W'(cell_height_q);
			gcbc_pkg::REG_BASELINE:    prdata = gcbc_pkg::APB_DATA_W'(baseline_q);
			gcbc_pkg::REG_ATLAS_WIDTH: prdata = gcbc_pkg::APB_DATA_W'(atlas_width_q);
			default:                   prdata = '0;
		endcase
	end

	// Pipeline flow control
	logic v_s1, v_s2, out_valid_q;
	logic adv_out, adv_s2, adv_s1, in_acc;

	assign adv_out  = !out_valid_q || !out_stall;
	assign adv_s2   = !v_s2 || adv_out;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;
	assign in_acc   = in_valid && adv_s1;

	// Source position counters
	logic [CNT_W-1:0] col_q, row_q;
	logic [CNT_W:0]   col_inc, row_inc;
	logic             new_row;

	assign col_inc = {1'b0, col_q} + (CNT_W+1)'(1);
	assign row_inc = {1'b0, row_q} + (CNT_W+1)'(1);
	assign new_row = CMP_W'(col_inc) >= CMP_W'(glyph_width);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (glyph_last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (new_row) begin
				col_q <= '0;
				row_q <= (row_inc == CNT_WRAP) ? '0 : row_inc[CNT_W-1:0];
			end else begin
				col_q <= (col_inc == CNT_WRAP) ? '0 : col_inc[CNT_W-1:0];
			end
		end
	end

	// Stage 1: input register
	logic [gcbc_pkg::PIXEL_W-1:0]            pixel_s1;
	logic [gcbc_pkg::COORD_W-1:0]            cell_x_s1, cell_y_s1;
	logic signed [gcbc_pkg::BEAR_LEFT_W-1:0] bl_s1;
	logic signed [gcbc_pkg::BEAR_TOP_W-1:0]  bt_s1;
	logic [gcbc_pkg::GLYPH_W_W-1:0]          gw_s1;
	logic [gcbc_pkg::SEG_W-1:0]              seg_s1;
	logic [CNT_W-1:0]                        col_s1, row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pixel_s1  <= pixel;
			cell_x_s1 <= cell_x;
			cell_y_s1 <= cell_y;
			bl_s1     <= bearing_left;
			bt_s1     <= bearing_top;
			gw_s1     <= glyph_width;
			seg_s1    <= slice_index;
			col_s1    <= col_q;
			row_s1    <= row_q;
		end
	end

	// Slice offset, cell-relative position and clip test
	logic [OFS_W-1:0]       offset;
	logic [CMP_W-1:0]       col_rel;
	logic                   in_slice;
	logic signed [DX_W-1:0] dx;
	logic signed [DY_W-1:0] dy;
	logic                   hit;
	logic [TXY_W-1:0]       tx, ty;

	always_comb begin
		offset   = OFS_W'(seg_s1) * OFS_W'(cell_width_q);
		in_slice = (CMP_W'(col_s1) < CMP_W'(gw_s1)) && (CMP_W'(col_s1) >= CMP_W'(offset));
		col_rel  = CMP_W'(col_s1) - CMP_W'(offset);
		// col_rel < glyph_width here, so it fits in a byte
		dx = DX_W'(bl_s1) + $signed({2'b00, col_rel[gcbc_pkg::GLYPH_W_W-1:0]});
		dy = $signed(DY_W'(baseline_q)) - DY_W'(bt_s1) + $signed(DY_W'(row_s1));
		hit = in_slice && (dx >= 0) && (dx < $signed(DX_W'(cell_width_q)))
			&& (dy >= 0) && (dy < $signed(DY_W'(cell_height_q)));
		tx = TXY_W'(cell_x_s1) + TXY_W'(dx[gcbc_pkg::CELL_WIDTH_W-1:0]);
		ty = TXY_W'(cell_y_s1) + TXY_W'(dy[gcbc_pkg::CELL_HEIGHT_W-1:0]);
	end

	// Stage 2: atlas coordinates
	logic                         hit_s2;
	logic [TXY_W-1:0]             tx_s2, ty_s2;
	logic [gcbc_pkg::PIXEL_W-1:0] pixel_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			hit_s2   <= hit;
			tx_s2    <= tx;
			ty_s2    <= ty;
			pixel_s2 <= pixel_s1;
		end
	end

	// Address and result register; drop clipped items
	logic [PROD_W-1:0]                  prod;
	logic [SUM_W-1:0]                   addr_sum;
	logic [gcbc_pkg::WRITE_ADDR_W-1:0]  write_addr_q;
	logic [gcbc_pkg::WRITE_VALUE_W-1:0] write_value_q;

	assign prod     = PROD_W'(ty_s2) * PROD_W'(atlas_width_q);
	assign addr_sum = SUM_W'(tx_s2) + SUM_W'(prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= v_s2 && hit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s2) begin
			write_addr_q  <= addr_sum[gcbc_pkg::WRITE_ADDR_W-1:0] & ADDR_MASK;
			write_value_q <= {4{pixel_s2}};
		end
	end

	assign out_valid   = out_valid_q;
	assign write_addr  = write_addr_q;
	assign write_value = write_value_q;

endmodule

>>> tb/sv/gcbc_checker.sv
module gcbc_checker
	import gcbc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [PIXEL_W-1:0]         pixel,
	input  logic [COORD_W-1:0]         cell_x,
	input  logic [COORD_W-1:0]         cell_y,
	input  logic signed [BEAR_LEFT_W-1:0] bearing_left,
	input  logic signed [BEAR_TOP_W-1:0]  bearing_top,
	input  logic [GLYPH_W_W-1:0]       glyph_width,
	input  logic [SEG_W-1:0]           slice_index,
	input  logic                       glyph_last,

	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [WRITE_ADDR_W-1:0]    write_addr,
	input  logic [WRITE_VALUE_W-1:0]   write_value,

	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [APB_ADDR_W-1:0]      paddr,
	input  logic [APB_DATA_W-1:0]      pwdata,
	input  logic                       pready,

	output int                         errors,
	output int                         pending
);

	typedef struct packed {
		logic [WRITE_ADDR_W-1:0]  addr;
		logic [WRITE_VALUE_W-1:0] value;
	} atlas_write_t;

	atlas_write_t expected_writes[$];
	atlas_write_t landed;
	atlas_write_t oldest;

	logic [CELL_WIDTH_W-1:0]  cell_w;
	logic [CELL_HEIGHT_W-1:0] cell_h;
	logic [BASELINE_W-1:0]    base_row;
	logic [ATLAS_WIDTH_W-1:0] stride;

	int src_col;
	int src_row;
	int err_count;

	// Place the current glyph byte in the atlas and advance the bitmap position.
	function automatic bit blit_byte(output atlas_write_t w);
		int     offset;
		longint tx;
		longint ty;
		longint addr;
		bit     hit;
		hit = 1'b0;
		w = '0;
		offset = int'(slice_index) * int'(cell_w);
		if (src_col < int'(glyph_width) && src_col >= offset) begin
			tx = longint'(cell_x) + longint'(bearing_left) + longint'(src_col - offset);
			ty = longint'(cell_y) + longint'(base_row) - longint'(bearing_top)
				+ longint'(src_row);
			if (tx >= longint'(cell_x) && ty >= longint'(cell_y) &&
					tx < longint'(cell_x) + longint'(cell_w) &&
					ty < longint'(cell_y) + longint'(cell_h)) begin
				addr = tx + ty * longint'(stride);
				w.addr = addr[WRITE_ADDR_W-1:0];
				w.value = {4{pixel}};
				hit = 1'b1;
			end
		end
		if (glyph_last) begin
			src_col = 0;
			src_row = 0;
		end else if (src_col + 1 >= int'(glyph_width)) begin
			src_col = 0;
			src_row = (src_row + 1) % MAX_GLYPH_DIM_DEF;
		end else begin
			src_col = src_col + 1;
		end
		return hit;
	endfunction

	task automatic flag_write(input string what);
		if (err_count < 10)
			$display("%0t: %s", $realtime, what);
		err_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_w = CELL_WIDTH_RST;
			cell_h = CELL_HEIGHT_RST;
			base_row = BASELINE_RST;
			stride = ATLAS_WIDTH_RST;
			src_col = 0;
			src_row = 0;
			err_count = 0;
			expected_writes.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			// check results before predicting: no item comes out in the cycle it goes in
			if (out_valid && !out_stall) begin
				if (expected_writes.size() == 0) begin
					flag_write($sformatf("unexpected write addr %h value %h",
						write_addr, write_value));
				end else begin
					oldest = expected_writes.pop_front();
					if (oldest.addr !== write_addr || oldest.value !== write_value)
						flag_write($sformatf(
							"write mismatch: expected addr %h value %h, got addr %h value %h",
							oldest.addr, oldest.value, write_addr, write_value));
				end
			end
			if (in_valid && !in_stall) begin
				if (blit_byte(landed))
					expected_writes.push_back(landed);
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_CELL_WIDTH:  cell_w = pwdata[CELL_WIDTH_W-1:0];
					REG_CELL_HEIGHT: cell_h = pwdata[CELL_HEIGHT_W-1:0];
					REG_BASELINE:    base_row = pwdata[BASELINE_W-1:0];
					REG_ATLAS_WIDTH: stride = pwdata[ATLAS_WIDTH_W-1:0];
					default: ;
				endcase
			end
			errors <= err_count;
			pending <= expected_writes.size();
		end
	end

endmodule

>>> tb/sv/tb.sv
module tb;
	import gcbc_pkg::*;

	typedef struct {
		logic [PIXEL_W-1:0]            pixel;
		logic [COORD_W-1:0]            cx;
		logic [COORD_W-1:0]            cy;
		logic signed [BEAR_LEFT_W-1:0] bl;
		logic signed [BEAR_TOP_W-1:0]  bt;
		logic [GLYPH_W_W-1:0]          gw;
		logic [SEG_W-1:0]              seg;
		logic                          last;
	} glyph_byte_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid;
	logic                          in_stall;
	logic [PIXEL_W-1:0]            pixel;
	logic [COORD_W-1:0]            cell_x;
	logic [COORD_W-1:0]            cell_y;
	logic signed [BEAR_LEFT_W-1:0] bearing_left;
	logic signed [BEAR_TOP_W-1:0]  bearing_top;
	logic [GLYPH_W_W-1:0]          glyph_width;
	logic [SEG_W-1:0]              slice_index;
	logic                          glyph_last;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [WRITE_ADDR_W-1:0]       write_addr;
	logic [WRITE_VALUE_W-1:0]      write_value;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [APB_ADDR_W-1:0]         paddr;
	logic [APB_DATA_W-1:0]         pwdata;
	logic [APB_DATA_W-1:0]         prdata;
	logic                          pready;
	int                            errors;
	int                            pending;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int sent = 0;
	int cfg_cw = CELL_WIDTH_RST;
	int cfg_ch = CELL_HEIGHT_RST;
	int cfg_base = BASELINE_RST;

	// cell width, cell height, baseline, atlas width; -1 picks random values
	int phase_cfg [0:8][0:3] = '{
		'{8, 16, 12, 1024},
		'{0, 16, 12, 1024},
		'{8, 16, 12, 0},
		'{127, 255, 127, 8191},
		'{1, 1, 0, 1},
		'{64, 128, 127, 4096},
		'{8, 0, 12, 100},
		'{-1, -1, -1, -1},
		'{-1, -1, -1, -1}
	};
	int phase_items [0:8] = '{120, 60, 120, 120, 120, 120, 60, 120, 120};
	int idle_modes [0:3][0:1] = '{'{0, 0}, '{50, 0}, '{0, 50}, '{33, 33}};

	glyph_cell_blit_clip_core u_dut (.*);
	gcbc_checker u_chk (.*);

	always #6 clk = ~clk;

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	initial begin
		#(12 * 400000);
		$display("tb failed");
		$finish;
	end

	function automatic glyph_byte_t mk(input int px, input int cx, input int cy,
			input int bl, input int bt, input int gw, input int seg, input bit last);
		glyph_byte_t b;
		b.pixel = PIXEL_W'(px);
		b.cx = COORD_W'(cx);
		b.cy = COORD_W'(cy);
		b.bl = BEAR_LEFT_W'(bl);
		b.bt = BEAR_TOP_W'(bt);
		b.gw = GLYPH_W_W'(gw);
		b.seg = SEG_W'(seg);
		b.last = last;
		return b;
	endfunction

	task automatic send_byte(input glyph_byte_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= b.pixel;
		cell_x <= b.cx;
		cell_y <= b.cy;
		bearing_left <= b.bl;
		bearing_top <= b.bt;
		glyph_width <= b.gw;
		slice_index <= b.seg;
		glyph_last <= b.last;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Hold the sender until every write has landed and the pipeline has emptied.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input int val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input int cw, input int ch, input int base, input int aw);
		drain();
		apb_write(REG_CELL_WIDTH, cw);
		apb_write(REG_CELL_HEIGHT, ch);
		apb_write(REG_BASELINE, base);
		apb_write(REG_ATLAS_WIDTH, aw);
		cfg_cw = cw;
		cfg_ch = ch;
		cfg_base = base;
	endtask

	// One glyph aimed mostly inside the cell; some are cut short or lose their end mark.
	// Never send more than max_bytes of it.
	task automatic send_glyph(input int max_bytes);
		glyph_byte_t b;
		int span;
		int gw;
		int seg;
		int rows;
		int total;
		int stop;
		int k;
		bit drop_last;
		span = (cfg_cw == 0) ? 1 : cfg_cw;
		seg = 0;
		gw = $urandom_range(1, (2 * span + 2 > 255) ? 255 : 2 * span + 2);
		if ($urandom_range(9) >= 7) begin
			seg = $urandom_range(1, 3);
			gw = seg * span + $urandom_range(1, span + 2);
			if (gw > 255)
				gw = 255;
		end
		rows = $urandom_range(1, (gw > 32) ? 2 : 6);
		total = gw * rows;
		stop = ($urandom_range(19) == 0) ? $urandom_range(1, total) : total;
		if (stop > max_bytes)
			stop = max_bytes;
		drop_last = ($urandom_range(9) == 0);
		b = mk(0, $urandom_range(4095), $urandom_range(4095),
			int'($urandom_range(0, span + 2)) - 3,
			cfg_base - (int'($urandom_range(0, cfg_ch + 2)) - 2), gw, seg, 1'b0);
		for (k = 0; k < stop; k++) begin
			b.pixel = PIXEL_W'($urandom_range(255));
			b.last = (k == stop - 1) && !drop_last;
			send_byte(b);
		end
	endtask

	initial begin
		int p;
		int k;
		int quota;
		in_valid <= 1'b0;
		pixel <= '0;
		cell_x <= '0;
		cell_y <= '0;
		bearing_left <= '0;
		bearing_top <= '0;
		glyph_width <= '0;
		slice_index <= '0;
		glyph_last <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on the reset register values
		send_byte(mk(0, 0, 0, 0, 12, 1, 0, 1'b1));
		send_byte(mk(255, 4095, 4095, 0, 12, 1, 0, 1'b1));
		send_byte(mk(170, 100, 100, -128, 12, 1, 0, 1'b1));
		send_byte(mk(85, 100, 100, 127, 12, 1, 0, 1'b1));
		send_byte(mk(15, 100, 100, 0, -256, 1, 0, 1'b1));
		send_byte(mk(240, 100, 100, 0, 255, 1, 0, 1'b1));
		// zero glyph width: every byte is a new row
		send_byte(mk(1, 10, 10, 0, 12, 0, 0, 1'b0));
		send_byte(mk(2, 10, 10, 0, 12, 0, 0, 1'b0));
		send_byte(mk(3, 10, 10, 0, 12, 0, 0, 1'b1));
		// width shrinks mid glyph: the column lands past the row end
		for (k = 0; k < 3; k++)
			send_byte(mk(16 + k, 20, 30, 1, 12, 4, 0, 1'b0));
		send_byte(mk(33, 20, 30, 1, 12, 2, 0, 1'b0));
		send_byte(mk(34, 20, 30, 1, 12, 2, 0, 1'b1));
		// second slice of a wide glyph: the first cell-width bytes are skipped
		for (k = 0; k < 10; k++)
			send_byte(mk($urandom_range(255), 300, 400, 0, 12, 10, 1, k == 9));
		send_byte(mk(77, 500, 600, 0, 12, 255, 15, 1'b1));

		for (p = 0; p < 9; p++) begin
			if (phase_cfg[p][0] < 0)
				configure($urandom_range(1, 64), $urandom_range(1, 128),
					$urandom_range(0, 127), $urandom_range(1, 4096));
			else
				configure(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
					phase_cfg[p][3]);
			send_idle_pct = idle_modes[p % 4][0];
			recv_stall_pct = idle_modes[p % 4][1];
			// tall narrow glyph: the row counter wraps back to the cell top
			if (p == 2)
				for (k = 0; k < 260; k++)
					send_byte(mk($urandom_range(255), $urandom_range(4095),
						$urandom_range(4095), 0, cfg_base, 1, 0, k == 259));
			quota = sent + phase_items[p];
			while (sent < quota) begin
				if ($urandom_range(149) == 0)
					drain();
				if ($urandom_range(99) < 80)
					send_glyph(quota - sent);
				else
					send_byte(mk($urandom_range(255), $urandom_range(4095),
						$urandom_range(4095), $urandom_range(255), $urandom_range(511),
						$urandom_range(255), $urandom_range(15), $urandom_range(7) == 0));
			end
		end

		recv_stall_pct = 0;
		drain();
		if (errors == 0 && pending == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
